// ----- rtl/core/ssnf_pkg.sv -----
// ssnf_pkg: types, segment codes and format codes of the seven-segment number formatter.
// No dependencies; imported by ssnf_glyphs and seven_segment_number_formatter.

package ssnf_pkg;

    typedef logic [1:0]      fmt_t;
    typedef logic [3:0][7:0] com_words_t;

    typedef struct packed {
        logic neg;
        fmt_t fmt;
    } glyph_ctrl_t;

    localparam fmt_t FMT_DECIMAL = 2'd0;
    localparam fmt_t FMT_WHOLE   = 2'd1;
    localparam fmt_t FMT_ERROR   = 2'd2;

    localparam logic [7:0] SEG_POINT = 8'h01;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_E     = 8'h5E;
    localparam logic [7:0] SEG_R     = 8'h42;

    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] code;
        unique case (d)
            4'd0:    code = 8'hBE;
            4'd1:    code = 8'hA0;
            4'd2:    code = 8'hDA;
            4'd3:    code = 8'hF8;
            4'd4:    code = 8'hE4;
            4'd5:    code = 8'h7C;
            4'd6:    code = 8'h7E;
            4'd7:    code = 8'hA8;
            4'd8:    code = 8'hFE;
            4'd9:    code = 8'hFC;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/ssnf_glyphs.sv -----
// ssnf_glyphs: decimal digits from the quotients, blanking, point, minus, error text,
// and the nibble interleave onto the four common words. Depends on ssnf_pkg.

module ssnf_glyphs (
    input  logic [13:0]              num,
    input  logic [9:0]               q1,
    input  logic [6:0]               q2,
    input  logic [3:0]               q3,
    input  ssnf_pkg::glyph_ctrl_t    ctrl,
    output ssnf_pkg::com_words_t     com_words
);
    import ssnf_pkg::*;

    logic [13:0]     q1x10;
    logic [9:0]      q2x10;
    logic [6:0]      q3x10;
    logic [13:0]     r0;
    logic [9:0]      r1;
    logic [6:0]      r2;
    logic [3:0]      d0, d1, d2, d3;
    logic            lead0, lead1, lead2;
    logic [3:0][7:0] codes;

    // each digit below the top one is a quotient less ten times the next quotient; the top digit is q3
    assign q1x10 = 14'({q1, 3'b000}) + 14'({q1, 1'b0});
    assign q2x10 = {q2, 3'b000} + 10'({q2, 1'b0});
    assign q3x10 = {q3, 3'b000} + 7'({q3, 1'b0});
    assign r0    = num - q1x10;
    assign r1    = q1 - q2x10;
    assign r2    = q2 - q3x10;
    assign d0    = r0[3:0];
    assign d1    = r1[3:0];
    assign d2    = r2[3:0];
    assign d3    = q3;

    assign lead0 = (d3 == 4'd0);
    assign lead1 = lead0 && (d2 == 4'd0);
    assign lead2 = lead1 && (d1 == 4'd0) && (ctrl.fmt == FMT_WHOLE);

    always_comb
    begin
        if (ctrl.fmt == FMT_ERROR)
        begin
            codes[0] = SEG_BLANK;
            codes[1] = SEG_E;
            codes[2] = SEG_R;
            codes[3] = SEG_R;
        end
        else
        begin
            codes[0] = lead0 ? SEG_BLANK : digit_code(d3);
            codes[1] = lead1 ? SEG_BLANK : digit_code(d2);
            codes[2] = lead2 ? SEG_BLANK : digit_code(d1);
            codes[3] = digit_code(d0);
            if (ctrl.fmt == FMT_DECIMAL)
            begin
                codes[3] = codes[3] | SEG_POINT;
            end
            // minus goes on the leftmost digit even when it is blank
            if (ctrl.neg)
            begin
                codes[0] = codes[0] | SEG_MINUS;
            end
        end
    end

    // common c takes bit (3-c) of each nibble: lo to even lines, hi to odd lines
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                com_words[c][2*k]   = codes[k][3-c];
                com_words[c][2*k+1] = codes[k][7-c];
            end
        end
    end

endmodule

// ----- rtl/core/seven_segment_number_formatter.sv -----
// seven_segment_number_formatter: top level, input register, scaling and digit
// quotient stages, result register. Depends on ssnf_pkg and ssnf_glyphs.

// A value in tenths is taken on any cycle with start high; busy is always low, so a new
// value may follow every cycle. Each result shows on the com words and shown_format for one
// cycle with done high. It passes through the input register, scale stage, quotient stage and
// result register, and results leave in the order values came in. The receiver cannot stall;
// done must be taken when it appears. Values from -199.9 to 999.9 show with one decimal, from
// -1999 to 9999 as a rounded whole number, and beyond that as Err.

module seven_segment_number_formatter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [19:0]  value_tenths,
    output logic                done,
    output logic [7:0]          com0_segments,
    output logic [7:0]          com1_segments,
    output logic [7:0]          com2_segments,
    output logic [7:0]          com3_segments,
    output ssnf_pkg::fmt_t      shown_format
);
    import ssnf_pkg::*;

    logic               in_valid_reg;
    logic signed [19:0] in_value_reg;

    logic               s1_valid_reg;
    logic [13:0]        s1_num_reg;
    glyph_ctrl_t        s1_ctrl_reg;

    logic               s2_valid_reg;
    logic [13:0]        s2_num_reg;
    logic [9:0]         s2_q1_reg;
    logic [6:0]         s2_q2_reg;
    logic [3:0]         s2_q3_reg;
    glyph_ctrl_t        s2_ctrl_reg;

    logic               done_reg;
    com_words_t         com_reg;
    fmt_t               fmt_reg;

    // scale stage
    logic               neg;
    logic [19:0]        mag;
    logic [16:0]        mag_round;
    logic [35:0]        prod_tenth;
    fmt_t               fmt_sel;
    logic [13:0]        s1_num_next;
    glyph_ctrl_t        s1_ctrl_next;

    // quotient stage
    logic [27:0]        prod_q1;
    logic [27:0]        prod_q2;
    logic [27:0]        prod_q3;

    com_words_t         com_next;

    assign busy = 1'b0;

    assign neg = in_value_reg[19];
    assign mag = neg ? (20'd0 - in_value_reg) : in_value_reg;

    always_comb
    begin
        priority if ((in_value_reg >= -20'sd1999) && (in_value_reg <= 20'sd9999))
        begin
            fmt_sel = FMT_DECIMAL;
        end
        else if ((in_value_reg >= -20'sd19990) && (in_value_reg <= 20'sd99990))
        begin
            fmt_sel = FMT_WHOLE;
        end
        else
        begin
            fmt_sel = FMT_ERROR;
        end
    end

    // (m + 5) / 10 by reciprocal, exact for m + 5 below 699050
    assign mag_round  = mag[16:0] + 17'd5;
    assign prod_tenth = 36'(mag_round) * 36'(19'd419431);

    assign s1_num_next       = (fmt_sel == FMT_DECIMAL) ? mag[13:0] : prod_tenth[35:22];
    assign s1_ctrl_next.neg  = neg;
    assign s1_ctrl_next.fmt  = fmt_sel;

    // quotients by 10, 100 and 1000, exact for num below 10240
    assign prod_q1 = 28'(s1_num_reg) * 28'(13'd6554);
    assign prod_q2 = 28'(s1_num_reg) * 28'(13'd5243);
    assign prod_q3 = 28'(s1_num_reg) * 28'(14'd8389);

    ssnf_glyphs u_glyphs (
        .num       (s2_num_reg),
        .q1        (s2_q1_reg),
        .q2        (s2_q2_reg),
        .q3        (s2_q3_reg),
        .ctrl      (s2_ctrl_reg),
        .com_words (com_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            s1_valid_reg <= in_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_value_reg <= value_tenths;
        end
        if (in_valid_reg)
        begin
            s1_num_reg  <= s1_num_next;
            s1_ctrl_reg <= s1_ctrl_next;
        end
        if (s1_valid_reg)
        begin
            s2_num_reg  <= s1_num_reg;
            s2_q1_reg   <= prod_q1[25:16];
            s2_q2_reg   <= prod_q2[25:19];
            s2_q3_reg   <= prod_q3[26:23];
            s2_ctrl_reg <= s1_ctrl_reg;
        end
        if (s2_valid_reg)
        begin
            com_reg <= com_next;
            fmt_reg <= s2_ctrl_reg.fmt;
        end
    end

    assign done          = done_reg;
    assign com0_segments = com_reg[0];
    assign com1_segments = com_reg[1];
    assign com2_segments = com_reg[2];
    assign com3_segments = com_reg[3];
    assign shown_format  = fmt_reg;

    // every transfer is followed by a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe missing four cycles after transfer");

    a_fmt_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (shown_format == FMT_DECIMAL || shown_format == FMT_WHOLE
                  || shown_format == FMT_ERROR))
        else $error("shown_format holds an unused code");

    // point on the last digit lands on line 6 of common 3
    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && shown_format == FMT_DECIMAL) |-> com3_segments[6])
        else $error("decimal point missing in one-decimal format");

    // error text has a blank first digit and no minus
    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && shown_format == FMT_ERROR) |->
            (com0_segments[1:0] == 2'b00 && com1_segments[1:0] == 2'b00
             && com2_segments[1:0] == 2'b00 && com3_segments[1:0] == 2'b00))
        else $error("first digit not blank in error text");

    // a negative value in range carries the minus on line 1 of common 1
    a_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value_tenths[19] && value_tenths >= -20'sd19990)
            |-> ##4 com1_segments[1])
        else $error("minus missing on negative value");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for seven_segment_number_formatter, directed edges then
// random values, in bursts and with input gaps. Depends on ssnf_pkg and the formatter RTL only.

module testbench;

    import ssnf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // digit glyphs 0..9, segment code per digit
    localparam logic [7:0] GLYPH [10] = '{
        8'hBE, 8'hA0, 8'hDA, 8'hF8, 8'hE4, 8'h7C, 8'h7E, 8'hA8, 8'hFE, 8'hFC
    };

    typedef struct packed {
        com_words_t coms;
        fmt_t       fmt;
    } shown_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [19:0] value_tenths;
    logic               done;
    logic [7:0]         com0_segments;
    logic [7:0]         com1_segments;
    logic [7:0]         com2_segments;
    logic [7:0]         com3_segments;
    fmt_t               shown_format;

    shown_t pending_displays[$];
    int     n_errors;
    int     values_sent;
    int     displays_checked;
    int     format_hits [3];
    int     cycle_count;

    seven_segment_number_formatter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value_tenths  (value_tenths),
        .done          (done),
        .com0_segments (com0_segments),
        .com1_segments (com1_segments),
        .com2_segments (com2_segments),
        .com3_segments (com3_segments),
        .shown_format  (shown_format)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected glyphs and per-common segment words for one value.
    function automatic shown_t predict_display(input logic signed [19:0] v);
        int         vi;
        int         mag;
        int         num;
        int         keep;
        int         div;
        int         d;
        int         k;
        int         c;
        logic       neg;
        logic       lead;
        logic [7:0] glyph [4];
        shown_t     r;

        vi   = v;
        neg  = vi < 0;
        mag  = neg ? -vi : vi;
        r    = '0;
        num  = 0;
        keep = 0;
        if (vi >= -1999 && vi <= 9999)
        begin
            r.fmt = FMT_DECIMAL;
            num   = mag;
            keep  = 2;
        end
        else if (vi >= -19990 && vi <= 99990)
        begin
            r.fmt = FMT_WHOLE;
            num   = (mag + 5) / 10;
            keep  = 3;
        end
        else
        begin
            r.fmt = FMT_ERROR;
        end

        if (r.fmt == FMT_ERROR)
        begin
            neg      = 1'b0;
            glyph[0] = SEG_BLANK;
            glyph[1] = SEG_E;
            glyph[2] = SEG_R;
            glyph[3] = SEG_R;
        end
        else
        begin
            div  = 1000;
            lead = 1'b1;
            for (k = 0; k < 4; k++)
            begin
                d = (num / div) % 10;
                if (d != 0 || k >= keep)
                    lead = 1'b0;
                glyph[k] = lead ? SEG_BLANK : GLYPH[d];
                div      = div / 10;
            end
            if (r.fmt == FMT_DECIMAL)
                glyph[3] = glyph[3] | SEG_POINT;
        end
        // minus goes on the leftmost digit even if it is blank
        if (neg)
            glyph[0] = glyph[0] | SEG_MINUS;

        // common c picks bit (3-c) of each nibble; lo nibble on even lines
        for (c = 0; c < 4; c++)
            for (k = 0; k < 4; k++)
            begin
                r.coms[c][2*k]   = glyph[k][3-c];
                r.coms[c][2*k+1] = glyph[k][7-c];
            end
        return r;
    endfunction

    task automatic send_value(input logic signed [19:0] v);
        @(negedge clk);
        start        <= 1'b1;
        value_tenths <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_displays.push_back(predict_display(v));
        values_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start        <= 1'b0;
            value_tenths <= 20'($urandom());
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [19:0] random_value();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: v = int'($urandom_range(0, 11998)) - 1999;
            3, 4:    v = int'($urandom_range(10000, 99990));
            5:       v = -int'($urandom_range(2000, 19990));
            // values ending in .4 or .5, around the half-way points of the whole-number rounding
            6:       v = (int'($urandom_range(1000, 9998)) * 10 + 4 + int'($urandom_range(0, 1)))
                         * ($urandom_range(0, 3) == 0 ? -1 : 1);
            // band edges, one either side
            7:       v = int'($urandom_range(0, 2)) - 1 +
                         ($urandom_range(0, 1) ? ($urandom_range(0, 1) ? 99990 : 9999)
                                               : ($urandom_range(0, 1) ? -19990 : -1999));
            default: v = int'($urandom() & 32'hFFFFF) - (($urandom() & 1) ? 0 : 0);
        endcase
        return 20'(v);
    endfunction

    task automatic test_decimal_band();
        send_value(20'sd0);
        send_value(20'sd1);
        send_value(20'sd9);
        send_value(20'sd10);
        send_value(20'sd105);
        send_value(20'sd9999);
        hold_off(2);
        send_value(-20'sd1);
        send_value(-20'sd10);
        send_value(-20'sd100);
        send_value(-20'sd1999);
    endtask

    task automatic test_whole_band();
        send_value(20'sd10000);
        send_value(20'sd10004);
        send_value(20'sd10005);
        send_value(20'sd99984);
        send_value(20'sd99990);
        hold_off(1);
        send_value(-20'sd2000);
        send_value(-20'sd2005);
        send_value(-20'sd19990);
    endtask

    task automatic test_error_text();
        send_value(20'sd99991);
        send_value(-20'sd19991);
        send_value(20'sh7FFFF);
        send_value(20'sh80000);
        send_value(20'shFFFFF);
    endtask

    task automatic test_random_values(input int count);
        int  i;
        bit  burst;
        burst = 1'b0;
        for (i = 0; i < count; i++)
        begin
            // alternate stretches of back-to-back transfers and gappy traffic
            if (i % 50 == 0)
                burst = $urandom_range(0, 2) == 0;
            send_value(random_value());
            if (!burst)
                hold_off(random_gap());
        end
    endtask

    always @(posedge clk)
    begin : result_check
        shown_t want;
        if (rst_n && done)
        begin
            if (pending_displays.size() == 0)
            begin
                $error("result with no value outstanding");
                n_errors++;
            end
            else
            begin
                want = pending_displays.pop_front();
                displays_checked++;
                if (want.fmt <= FMT_ERROR)
                    format_hits[want.fmt]++;
                if (com0_segments !== want.coms[0])
                begin
                    $error("com0_segments: expected %h, got %h", want.coms[0], com0_segments);
                    n_errors++;
                end
                if (com1_segments !== want.coms[1])
                begin
                    $error("com1_segments: expected %h, got %h", want.coms[1], com1_segments);
                    n_errors++;
                end
                if (com2_segments !== want.coms[2])
                begin
                    $error("com2_segments: expected %h, got %h", want.coms[2], com2_segments);
                    n_errors++;
                end
                if (com3_segments !== want.coms[3])
                begin
                    $error("com3_segments: expected %h, got %h", want.coms[3], com3_segments);
                    n_errors++;
                end
                if (shown_format !== want.fmt)
                begin
                    $error("shown_format: expected %0d, got %0d", want.fmt, shown_format);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("seven_segment_number_formatter verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        value_tenths = '0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        test_decimal_band();
        test_whole_band();
        test_error_text();
        test_random_values(850);

        @(negedge clk);
        start <= 1'b0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d values in, %0d displays compared", values_sent, displays_checked);
        $display("one-decimal %0d, whole-number %0d, error text %0d",
                 format_hits[0], format_hits[1], format_hits[2]);
        if (n_errors == 0)
            $display("seven_segment_number_formatter verification clean");
        else
            $display("seven_segment_number_formatter verification failed");
        $finish;
    end

endmodule
